// ===== rtl/core/ptc_pkg.sv =====
// Shared types, register indexes and arithmetic helpers for the compensation block
package ptc_pkg;

  // Number of quotient bits, one per divider cell
  localparam int unsigned DivBits = 32;

  // Configuration register indexes
  localparam logic [2:0] RegAc1Ac2 = 3'd0;
  localparam logic [2:0] RegAc3Ac4 = 3'd1;
  localparam logic [2:0] RegAc5Ac6 = 3'd2;
  localparam logic [2:0] RegB1B2   = 3'd3;
  localparam logic [2:0] RegMcMd   = 3'd4;

  // Fixed compensation constants
  localparam logic [31:0] TempOffset   = 32'd4000;
  localparam logic [31:0] HalfPressScl = 32'd25000;
  localparam logic [31:0] PressRound   = 32'd32768;
  localparam logic [31:0] CoefA        = 32'd3038;
  localparam logic [31:0] CoefB        = 32'hFFFF_E343;  // -7357
  localparam logic [31:0] CoefC        = 32'd3791;

  typedef struct packed {
    logic [15:0] raw_temperature;
    logic [16:0] raw_pressure;
  } in_t;

  typedef struct packed {
    logic signed [27:0] temperature_tenths;
    logic signed [31:0] pressure_pa;
    logic               status;
  } out_t;

  // Partial remainder, dividend/quotient shift word and divisor of one divider cell
  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] quo;
    logic [31:0] dvs;
  } div_lane_t;

  // Data riding alongside the temperature divide
  typedef struct packed {
    logic [31:0] x1;
    logic [16:0] up;
    logic        fail;
    logic        neg;
  } div1_side_t;

  // Data riding alongside the pressure divide
  typedef struct packed {
    logic [27:0] t;
    logic        fail;
    logic        dbl;
  } div2_side_t;

  // Arithmetic shift right of a 32-bit word
  function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] n);
    return 32'($signed(v) >>> n);
  endfunction

  // Sign-extend a 16-bit half word
  function automatic logic [31:0] sx16(input logic [15:0] h);
    return {{16{h[15]}}, h};
  endfunction

endpackage

// ===== rtl/core/ptc_div_cell.sv =====
// One restoring-division cell: resolves one quotient bit and registers the lane
module ptc_div_cell #(
  parameter int unsigned SIDE_W = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  ptc_pkg::div_lane_t    in_lane,
  input  logic [SIDE_W-1:0]     in_side,
  output logic                  out_valid,
  output ptc_pkg::div_lane_t    out_lane,
  output logic [SIDE_W-1:0]     out_side
);

  logic [32:0]        trial;
  logic               fits;
  ptc_pkg::div_lane_t lane_nxt;
  logic               valid_r;
  ptc_pkg::div_lane_t lane_r;
  logic [SIDE_W-1:0]  side_r;

  // Shift in the next dividend bit and try the subtraction
  always_comb begin
    trial        = {in_lane.rem, in_lane.quo[31]};
    fits         = trial >= {1'b0, in_lane.dvs};
    lane_nxt.dvs = in_lane.dvs;
    lane_nxt.quo = {in_lane.quo[30:0], fits};
    lane_nxt.rem = fits ? 32'(trial - {1'b0, in_lane.dvs}) : trial[31:0];
  end

  // Advance the valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  // Hand the lane to the next cell
  always_ff @(posedge clk) begin
    lane_r <= lane_nxt;
    side_r <= in_side;
  end

  assign out_valid = valid_r;
  assign out_lane  = lane_r;
  assign out_side  = side_r;

endmodule

// ===== rtl/core/ptc_div_chain.sv =====
// Row of division cells giving a 32-bit unsigned quotient, one transaction per cycle
module ptc_div_chain #(
  parameter int unsigned SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [31:0]       in_num,
  input  logic [31:0]       in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [31:0]       out_quo,
  output logic [SIDE_W-1:0] out_side
);

  logic               valid_w [0:ptc_pkg::DivBits];
  ptc_pkg::div_lane_t lane_w  [0:ptc_pkg::DivBits];
  logic [SIDE_W-1:0]  side_w  [0:ptc_pkg::DivBits];

  // Load the first lane with an empty remainder
  assign valid_w[0] = in_valid;
  assign lane_w[0]  = '{rem: 32'd0, quo: in_num, dvs: in_den};
  assign side_w[0]  = in_side;

  for (genvar i = 0; i < ptc_pkg::DivBits; i++) begin : g_cell
    ptc_div_cell #(
      .SIDE_W(SIDE_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (valid_w[i]),
      .in_lane  (lane_w[i]),
      .in_side  (side_w[i]),
      .out_valid(valid_w[i+1]),
      .out_lane (lane_w[i+1]),
      .out_side (side_w[i+1])
    );
  end

  assign out_valid = valid_w[ptc_pkg::DivBits];
  assign out_quo   = lane_w[ptc_pkg::DivBits].quo;
  assign out_side  = side_w[ptc_pkg::DivBits];

endmodule

// ===== rtl/core/pressure_temperature_compensation.sv =====
// Top level: barometric integer compensation pipeline with two divider cell rows
//
// One measurement pair is taken every cycle (busy stays low) and each result
// appears on out_result with out_valid high for one cycle; results come out in
// order. The receiver cannot stall, so capture out_result whenever out_valid
// is high. The pipeline is made of the two rows of 32 restoring-division cells
// (temperature correction and pressure quotient) plus a capture register and
// eleven multiply and add stages. status set means a zero divisor was met and
// both values read zero.
// Write the calibration registers only while no transaction is in flight.
module pressure_temperature_compensation (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  ptc_pkg::in_t  in_data,
  output logic          out_valid,
  output ptc_pkg::out_t out_result,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_wdata
);

  // Calibration registers
  logic [31:0] cal_ac1_ac2_r, cal_ac3_ac4_r, cal_ac5_ac6_r, cal_b1_b2_r, cal_mc_md_r;
  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_ac1_ac2_r <= '0;
      cal_ac3_ac4_r <= '0;
      cal_ac5_ac6_r <= '0;
      cal_b1_b2_r   <= '0;
      cal_mc_md_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ptc_pkg::RegAc1Ac2: cal_ac1_ac2_r <= cfg_wdata;
        ptc_pkg::RegAc3Ac4: cal_ac3_ac4_r <= cfg_wdata;
        ptc_pkg::RegAc5Ac6: cal_ac5_ac6_r <= cfg_wdata;
        ptc_pkg::RegB1B2:   cal_b1_b2_r   <= cfg_wdata;
        ptc_pkg::RegMcMd:   cal_mc_md_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Unpack calibration words
  always_comb begin
    ac1 = ptc_pkg::sx16(cal_ac1_ac2_r[31:16]);
    ac2 = ptc_pkg::sx16(cal_ac1_ac2_r[15:0]);
    ac3 = ptc_pkg::sx16(cal_ac3_ac4_r[31:16]);
    ac4 = {16'd0, cal_ac3_ac4_r[15:0]};
    ac5 = {16'd0, cal_ac5_ac6_r[31:16]};
    ac6 = {16'd0, cal_ac5_ac6_r[15:0]};
    b1  = ptc_pkg::sx16(cal_b1_b2_r[31:16]);
    b2  = ptc_pkg::sx16(cal_b1_b2_r[15:0]);
    mc  = ptc_pkg::sx16(cal_mc_md_r[31:16]);
    md  = ptc_pkg::sx16(cal_mc_md_r[15:0]);
  end

  assign busy = 1'b0;

  // Capture the transaction
  logic        s0_v_r;
  logic [15:0] s0_ut_r;
  logic [16:0] s0_up_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else begin
      s0_v_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s0_ut_r <= in_data.raw_temperature;
    s0_up_r <= in_data.raw_pressure;
  end

  // Uncorrected temperature term
  logic        s1_v_r;
  logic [31:0] s1_x1_r;
  logic [16:0] s1_up_r;
  logic [31:0] s1_x1_nxt;

  assign s1_x1_nxt = ptc_pkg::asr32((({16'd0, s0_ut_r} - ac6) * ac5), 5'd15);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_x1_r <= s1_x1_nxt;
    s1_up_r <= s0_up_r;
  end

  // Prepare magnitudes for the temperature divide
  logic [31:0]         d1_num, d1_den, d1_n, d1_d;
  ptc_pkg::div1_side_t d1_side_in, d1_side_out;
  logic                d1_valid_out;
  logic [31:0]         d1_quo;

  always_comb begin
    d1_n             = mc << 11;
    d1_d             = s1_x1_r + md;
    d1_num           = d1_n[31] ? 32'(-d1_n) : d1_n;
    d1_den           = d1_d[31] ? 32'(-d1_d) : d1_d;
    d1_side_in.x1    = s1_x1_r;
    d1_side_in.up    = s1_up_r;
    d1_side_in.fail  = d1_d == 32'd0;
    d1_side_in.neg   = d1_n[31] ^ d1_d[31];
  end

  ptc_div_chain #(
    .SIDE_W($bits(ptc_pkg::div1_side_t))
  ) u_div_temp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (s1_v_r),
    .in_num   (d1_num),
    .in_den   (d1_den),
    .in_side  (d1_side_in),
    .out_valid(d1_valid_out),
    .out_quo  (d1_quo),
    .out_side (d1_side_out)
  );

  // Corrected temperature B5
  logic        s3_v_r, s3_fail_r;
  logic [31:0] s3_b5_r;
  logic [16:0] s3_up_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else begin
      s3_v_r <= d1_valid_out;
    end
  end

  always_ff @(posedge clk) begin
    s3_b5_r   <= d1_side_out.x1 + (d1_side_out.neg ? 32'(-d1_quo) : d1_quo);
    s3_up_r   <= d1_side_out.up;
    s3_fail_r <= d1_side_out.fail;
  end

  // B6 and the temperature output
  logic        s4_v_r, s4_fail_r;
  logic [31:0] s4_b6_r, t_full;
  logic [27:0] s4_t_r;
  logic [16:0] s4_up_r;

  assign t_full = ptc_pkg::asr32(s3_b5_r + 32'd8, 5'd4);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s4_b6_r   <= s3_b5_r - ptc_pkg::TempOffset;
    s4_t_r    <= t_full[27:0];
    s4_up_r   <= s3_up_r;
    s4_fail_r <= s3_fail_r;
  end

  // First products of B6
  logic        s5_v_r, s5_fail_r;
  logic [31:0] s5_sq_r, s5_ac2b6_r, s5_ac3b6_r;
  logic [27:0] s5_t_r;
  logic [16:0] s5_up_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else begin
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s5_sq_r    <= s4_b6_r * s4_b6_r;
    s5_ac2b6_r <= ac2 * s4_b6_r;
    s5_ac3b6_r <= ac3 * s4_b6_r;
    s5_t_r     <= s4_t_r;
    s5_up_r    <= s4_up_r;
    s5_fail_r  <= s4_fail_r;
  end

  // Products of the square term
  logic        s6_v_r, s6_fail_r;
  logic [31:0] s6_b2sq_r, s6_b1sq_r, s6_x2a_r, s6_x1c_r, sq;
  logic [27:0] s6_t_r;
  logic [16:0] s6_up_r;

  assign sq = ptc_pkg::asr32(s5_sq_r, 5'd12);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_v_r <= 1'b0;
    end else begin
      s6_v_r <= s5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s6_b2sq_r <= b2 * sq;
    s6_b1sq_r <= b1 * sq;
    s6_x2a_r  <= ptc_pkg::asr32(s5_ac2b6_r, 5'd11);
    s6_x1c_r  <= ptc_pkg::asr32(s5_ac3b6_r, 5'd13);
    s6_t_r    <= s5_t_r;
    s6_up_r   <= s5_up_r;
    s6_fail_r <= s5_fail_r;
  end

  // B3 and the B4 factor
  logic        s7_v_r, s7_fail_r;
  logic [31:0] s7_b3_r, s7_t4_r, x3a, x3b, b3_pre;
  logic [27:0] s7_t_r;
  logic [16:0] s7_up_r;

  always_comb begin
    x3a    = ptc_pkg::asr32(s6_b2sq_r, 5'd11) + s6_x2a_r;
    b3_pre = (((ac1 << 2) + x3a) << 1) + 32'd2;
    x3b    = ptc_pkg::asr32(s6_x1c_r + ptc_pkg::asr32(s6_b1sq_r, 5'd16) + 32'd2, 5'd2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_v_r <= 1'b0;
    end else begin
      s7_v_r <= s6_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s7_b3_r   <= ptc_pkg::asr32(b3_pre, 5'd2);
    s7_t4_r   <= x3b + ptc_pkg::PressRound;
    s7_t_r    <= s6_t_r;
    s7_up_r   <= s6_up_r;
    s7_fail_r <= s6_fail_r;
  end

  // B4 and B7
  logic        s8_v_r, s8_fail_r;
  logic [31:0] s8_b4_r, s8_b7_r, b4_prod;
  logic [27:0] s8_t_r;

  assign b4_prod = ac4 * s7_t4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s8_v_r <= 1'b0;
    end else begin
      s8_v_r <= s7_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s8_b4_r   <= b4_prod >> 15;
    s8_b7_r   <= ({15'd0, s7_up_r} - s7_b3_r) * ptc_pkg::HalfPressScl;
    s8_t_r    <= s7_t_r;
    s8_fail_r <= s7_fail_r;
  end

  // Pressure divide: double before or after depending on the top bit of B7
  ptc_pkg::div2_side_t d2_side_in, d2_side_out;
  logic [31:0]         d2_num, d2_quo;
  logic                d2_valid_out;

  always_comb begin
    d2_num          = s8_b7_r[31] ? s8_b7_r : (s8_b7_r << 1);
    d2_side_in.t    = s8_t_r;
    d2_side_in.fail = s8_fail_r || (s8_b4_r == 32'd0);
    d2_side_in.dbl  = s8_b7_r[31];
  end

  ptc_div_chain #(
    .SIDE_W($bits(ptc_pkg::div2_side_t))
  ) u_div_press (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (s8_v_r),
    .in_num   (d2_num),
    .in_den   (s8_b4_r),
    .in_side  (d2_side_in),
    .out_valid(d2_valid_out),
    .out_quo  (d2_quo),
    .out_side (d2_side_out)
  );

  // Raw pressure P
  logic        s9_v_r, s9_fail_r;
  logic [31:0] s9_p_r;
  logic [27:0] s9_t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s9_v_r <= 1'b0;
    end else begin
      s9_v_r <= d2_valid_out;
    end
  end

  always_ff @(posedge clk) begin
    s9_p_r    <= d2_side_out.dbl ? (d2_quo << 1) : d2_quo;
    s9_t_r    <= d2_side_out.t;
    s9_fail_r <= d2_side_out.fail;
  end

  // Correction products
  logic        s10_v_r, s10_fail_r;
  logic [31:0] s10_pqsq_r, s10_mb_r, s10_p_r, pq;
  logic [27:0] s10_t_r;

  assign pq = ptc_pkg::asr32(s9_p_r, 5'd8);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s10_v_r <= 1'b0;
    end else begin
      s10_v_r <= s9_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s10_pqsq_r <= pq * pq;
    s10_mb_r   <= ptc_pkg::CoefB * s9_p_r;
    s10_p_r    <= s9_p_r;
    s10_t_r    <= s9_t_r;
    s10_fail_r <= s9_fail_r;
  end

  logic        s11_v_r, s11_fail_r;
  logic [31:0] s11_ma_r, s11_x2_r, s11_p_r;
  logic [27:0] s11_t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s11_v_r <= 1'b0;
    end else begin
      s11_v_r <= s10_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s11_ma_r   <= s10_pqsq_r * ptc_pkg::CoefA;
    s11_x2_r   <= ptc_pkg::asr32(s10_mb_r, 5'd16);
    s11_p_r    <= s10_p_r;
    s11_t_r    <= s10_t_r;
    s11_fail_r <= s10_fail_r;
  end

  // Final pressure and output register
  logic          out_valid_r;
  ptc_pkg::out_t out_result_r, out_result_nxt;
  logic [31:0]   corr;

  always_comb begin
    corr = ptc_pkg::asr32(ptc_pkg::asr32(s11_ma_r, 5'd16) + s11_x2_r + ptc_pkg::CoefC, 5'd4);
    out_result_nxt.status             = s11_fail_r;
    out_result_nxt.temperature_tenths = s11_fail_r ? '0 : s11_t_r;
    out_result_nxt.pressure_pa        = s11_fail_r ? '0 : s11_p_r + corr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s11_v_r;
    end
  end

  always_ff @(posedge clk) begin
    out_result_r <= out_result_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule

// ===== rtl/core/ptc_checker.sv =====
// Port-level checks for the compensation block, bound to the top level
module ptc_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input logic          out_valid,
  input ptc_pkg::out_t out_result
);

  // Sample edges from taking a transaction to seeing its result
  localparam int unsigned Latency = 76;

  // Every accepted transaction gives a result after the fixed latency
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##Latency out_valid)
    else $error("result missing after accepted transaction");

  // No result without a transaction taken earlier
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, Latency))
    else $error("result without matching transaction");

  // A failed result carries zero values
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result.status) |->
      (out_result.pressure_pa == 32'sd0 && out_result.temperature_tenths == 28'sd0))
    else $error("failed result with non-zero values");

  // Input side never stalls
  assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

endmodule

bind pressure_temperature_compensation ptc_checker u_ptc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_result(out_result)
);

// ===== tb/sv/tb.sv =====
// Testbench for the pressure and temperature compensation pipeline
`timescale 1ns / 100ps

module tb;

  localparam int Latency    = 76;
  localparam int CycleLimit = 400000;
  localparam int RandItems  = 800;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  ptc_pkg::in_t  in_data = '0;
  logic          out_valid;
  ptc_pkg::out_t out_result;
  logic          cfg_we = 1'b0;
  logic [2:0]    cfg_index = '0;
  logic [31:0]   cfg_wdata = '0;

  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  // Calibration words as the block holds them
  logic [31:0] cal_word [5];

  pressure_temperature_compensation dut (
    .clk, .rst_n, .start, .busy, .in_data, .out_valid, .out_result,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  always #1 clk = ~clk;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  function automatic logic [31:0] shr_s(input logic [31:0] v, input int n);
    return 32'($signed(v) >>> n);
  endfunction

  function automatic logic [31:0] ext16(input logic [15:0] h);
    return {{16{h[15]}}, h};
  endfunction

  function automatic logic [31:0] div_trunc(input logic [31:0] n, input logic [31:0] d);
    longint q;
    q = longint'($signed(n)) / longint'($signed(d));
    return q[31:0];
  endfunction

  // Compute the compensated pair for one measurement
  function automatic ptc_pkg::out_t compensate(input ptc_pkg::in_t m);
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, ut, up;
    logic [31:0] x1, x2, x3, den, b5, t, b6, sq, b3, b4, b7, p, pq;
    ptc_pkg::out_t r;
    ac1 = ext16(cal_word[ptc_pkg::RegAc1Ac2][31:16]);
    ac2 = ext16(cal_word[ptc_pkg::RegAc1Ac2][15:0]);
    ac3 = ext16(cal_word[ptc_pkg::RegAc3Ac4][31:16]);
    ac4 = {16'd0, cal_word[ptc_pkg::RegAc3Ac4][15:0]};
    ac5 = {16'd0, cal_word[ptc_pkg::RegAc5Ac6][31:16]};
    ac6 = {16'd0, cal_word[ptc_pkg::RegAc5Ac6][15:0]};
    b1 = ext16(cal_word[ptc_pkg::RegB1B2][31:16]);
    b2 = ext16(cal_word[ptc_pkg::RegB1B2][15:0]);
    mc = ext16(cal_word[ptc_pkg::RegMcMd][31:16]);
    md = ext16(cal_word[ptc_pkg::RegMcMd][15:0]);
    ut = {16'd0, m.raw_temperature};
    up = {15'd0, m.raw_pressure};
    r = '0;
    r.status = 1'b1;
    x1 = shr_s((ut - ac6) * ac5, 15);
    den = x1 + md;
    if (den == 0) return r;
    x2 = div_trunc(mc << 11, den);
    b5 = x1 + x2;
    t = shr_s(b5 + 32'd8, 4);
    b6 = b5 - 32'd4000;
    sq = shr_s(b6 * b6, 12);
    x1 = shr_s(b2 * sq, 11);
    x2 = shr_s(ac2 * b6, 11);
    x3 = x1 + x2;
    b3 = shr_s(((ac1 * 32'd4 + x3) << 1) + 32'd2, 2);
    x1 = shr_s(ac3 * b6, 13);
    x2 = shr_s(b1 * sq, 16);
    x3 = shr_s(x1 + x2 + 32'd2, 2);
    b4 = (ac4 * (x3 + 32'd32768)) >> 15;
    b7 = (up - b3) * 32'd25000;
    if (b4 == 0) return r;
    if (!b7[31]) p = (b7 * 32'd2) / b4;
    else p = (b7 / b4) * 32'd2;
    pq = shr_s(p, 8);
    x1 = shr_s((pq * pq) * 32'd3038, 16);
    x2 = shr_s(32'hFFFF_E343 * p, 16);
    p = p + shr_s(x1 + x2 + 32'd3791, 4);
    r.temperature_tenths = t[27:0];
    r.pressure_pa = p;
    r.status = 1'b0;
    return r;
  endfunction

  class reading_scoreboard;
    ptc_pkg::out_t pending[$];

    function void note_measurement(input ptc_pkg::in_t m);
      pending.push_back(compensate(m));
    endfunction

    task check_reading(input ptc_pkg::out_t got);
      ptc_pkg::out_t want;
      if (pending.size() == 0) begin
        report_mismatch("result with nothing expected");
        return;
      end
      want = pending.pop_front();
      if (got.temperature_tenths !== want.temperature_tenths)
        report_mismatch($sformatf("temperature got %0d want %0d",
                                  got.temperature_tenths, want.temperature_tenths));
      if (got.pressure_pa !== want.pressure_pa)
        report_mismatch($sformatf("pressure got %0d want %0d",
                                  got.pressure_pa, want.pressure_pa));
      if (got.status !== want.status)
        report_mismatch($sformatf("status got %0b want %0b", got.status, want.status));
    endtask
  endclass

  reading_scoreboard board = new();

  // Check every strobed result; note every accepted measurement
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) board.check_reading(out_result);
      if (start && !busy) board.note_measurement(in_data);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Drive one register write; the caller drops the write enable afterwards
  task automatic write_cal(input logic [2:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx <= ptc_pkg::RegMcMd) cal_word[idx] = val;
  endtask

  // Wait for the pipeline to drain before touching calibration
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_cal(input logic [31:0] w0, w1, w2, w3, w4);
    drain();
    write_cal(ptc_pkg::RegAc1Ac2, w0);
    write_cal(ptc_pkg::RegAc3Ac4, w1);
    write_cal(ptc_pkg::RegAc5Ac6, w2);
    write_cal(ptc_pkg::RegB1B2, w3);
    write_cal(ptc_pkg::RegMcMd, w4);
    cfg_we <= 1'b0;
  endtask

  // Present one measurement and hold until taken; start stays high for the next
  task automatic send(input logic [15:0] ut, input logic [16:0] up);
    in_data <= '{raw_temperature: ut, raw_pressure: up};
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Burst of random measurements with random gaps
  task automatic send_random(input int count);
    int sent;
    int burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 30);
      while (burst > 0 && sent < count) begin
        if ($urandom_range(0, 9) == 0)
          send(16'($urandom),
               17'($urandom_range(0, 131071)) | ($urandom_range(0, 1) ? 17'h10000 : 17'h0));
        else
          send(16'($urandom_range(20000, 34000)), 17'($urandom_range(20000, 45000)));
        burst--;
        sent++;
      end
      if ($urandom_range(0, 2) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  endtask

  task automatic random_cal();
    load_cal($urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  // Typical factory calibration set
  task automatic typical_cal();
    load_cal({16'd408, -16'sd72}, {-16'sd14383, 16'd32741}, {16'd32757, 16'd23153},
             {16'd6190, 16'd4}, {-16'sd8711, 16'd2868});
  endtask

  initial begin
    for (int i = 0; i < 5; i++) cal_word[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset calibration: zero divisors everywhere
    send(16'd27898, 17'd23843);
    send(16'hFFFF, 17'h1FFFF);

    typical_cal();
    send(16'd27898, 17'd23843);
    send(16'd0, 17'd0);
    send(16'hFFFF, 17'h1FFFF);
    send(16'h8000, 17'h10000);
    send(16'd23153, 17'd40000);

    // Temperature divisor zero: ac5 zero and md zero
    load_cal({16'd408, -16'sd72}, {-16'sd14383, 16'd32741}, {16'd0, 16'd23153},
             {16'd6190, 16'd4}, {-16'sd8711, 16'd0});
    send(16'd27898, 17'd23843);

    // Pressure divisor zero: ac4 zero
    load_cal({16'd408, -16'sd72}, {-16'sd14383, 16'd0}, {16'd32757, 16'd23153},
             {16'd6190, 16'd4}, {-16'sd8711, 16'd2868});
    send(16'd27898, 17'd23843);

    // Extreme calibration words
    load_cal('1, '1, '1, '1, '1);
    send(16'hFFFF, 17'h1FFFF);
    send(16'd0, 17'd0);
    load_cal(32'h8000_8000, 32'h8000_FFFF, 32'hFFFF_0000, 32'h8000_8000, 32'h7FFF_8000);
    send(16'h1234, 17'h0ABCD);
    send(16'hFFFF, 17'h1FFFF);
    drain();
    write_cal(3'd7, 32'hDEAD_BEEF);
    cfg_we <= 1'b0;

    typical_cal();
    send_random(RandItems / 2);
    // Let everything settle before the next burst
    drain();
    send_random(RandItems / 8);
    for (int k = 0; k < 3; k++) begin
      random_cal();
      send_random(RandItems / 8);
    end

    drain();
    repeat (Latency + 10) @(posedge clk);
    if (mismatch_count == 0 && board.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
